// ===== rtl/asp_pkg.sv =====
// Shared constants, codes and types for the sparkline plotter.
package asp_pkg;

    localparam int COLUMNS = 128;
    localparam int AW      = $clog2(COLUMNS);
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);

    localparam logic [AW-1:0] LAST_POS    = AW'(COLUMNS - 1);
    localparam logic [8:0]    COLUMNS_W   = 9'(COLUMNS);
    localparam logic [7:0]    WINDOW_ROWS = 8'd40;
    localparam logic [7:0]    TOP_OFFSET  = 8'd39;
    localparam logic [7:0]    TOP_MASK    = 8'h80;
    localparam logic [2:0]    BOTTOM_PAGE = 3'd7;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_RENDER   = 1'b1;
    localparam logic KIND_SHIFT  = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef struct packed {
        logic          op;
        logic [7:0]    sample;
        logic [6:0]    column;
        logic [AW-1:0] addr;
        logic          col_ok;
    } t_cmd;

endpackage

// ===== rtl/asp_if.sv =====
// Valid/ready channel interfaces for input and result words.
interface asp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] sample;
    logic [6:0] column;

    modport source (output valid, output mode, output sample, output column, input ready);
    modport sink   (input valid, input mode, input sample, input column, output ready);
endinterface

interface asp_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] shift;
    logic [6:0] column_out;
    logic [2:0] page;
    logic [7:0] pixel_mask;
    logic       visible;

    modport source (output valid, output kind, output shift, output column_out,
                    output page, output pixel_mask, output visible, input ready);
    modport sink   (input valid, input kind, input shift, input column_out,
                    input page, input pixel_mask, input visible, output ready);
endinterface

// ===== rtl/autoscaled_sparkline_plotter.sv =====
// Top level of the autoscaled sparkline plotter.
// Load words (mode 0) fill a frame of COLUMNS samples in order; the last one
// returns a shift report. Render words (mode 1) after a full frame return one
// pixel result each; renders while no full frame is held (before the first, or
// once a new frame has begun loading) return nothing. Sustained rate is one
// word per cycle while results are taken, set by the single back-end stage that
// does one sample-store write or read per cycle. A taken word passes through the
// front register, the queue, the store read and the output register. The sample
// store needs no clearing after reset.
module autoscaled_sparkline_plotter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asp_in_if.sink    i_in,
    asp_out_if.source o_out
);
    import asp_pkg::*;

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    asp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cmd   (f_cmd)
    );

    asp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    asp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cmd   (q_cmd),
        .o_out   (o_out)
    );
endmodule

// ===== rtl/asp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module asp_ram #(
    parameter int W = 8,
    parameter int D = 128
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/asp_front.sv =====
// Front end: takes input words, classifies them and decodes the column.
module asp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    asp_in_if.sink          i_in,
    output logic            o_valid,
    input  logic            i_ready,
    output asp_pkg::t_cmd   o_cmd
);
    import asp_pkg::*;

    logic       r_v;
    t_cmd       r_cmd;
    t_cmd       n_cmd;
    logic [8:0] col_w;

    assign i_in.ready = !r_v || i_ready;
    assign col_w      = 9'(i_in.column);

    always_comb begin
        n_cmd.op     = i_in.mode ? OP_RENDER : OP_LOAD;
        n_cmd.sample = i_in.sample;
        n_cmd.column = i_in.column;
        n_cmd.addr   = col_w[AW-1:0];
        n_cmd.col_ok = col_w < COLUMNS_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in.ready) begin
            r_v <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_v;
    assign o_cmd   = r_cmd;
endmodule

// ===== rtl/asp_queue.sv =====
// Short command queue between front and back end.
module asp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  asp_pkg::t_cmd   i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output asp_pkg::t_cmd   o_cmd
);
    import asp_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           push;
    logic           pop;

    assign o_ready = r_cnt != (QAW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end
endmodule

// ===== rtl/asp_back.sv =====
// Back end: min/max tracking, sample store, shift report and pixel results.
module asp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  asp_pkg::t_cmd   i_cmd,
    asp_out_if.source       o_out
);
    import asp_pkg::*;

    logic [AW-1:0] r_load_count;
    logic [7:0]    r_max;
    logic [7:0]    r_min;
    logic [7:0]    r_scale_shift;
    logic          r_frame_ready;

    logic          r_s2_v;
    logic          r_s2_kind;
    logic [7:0]    r_s2_shift;
    logic [6:0]    r_s2_col;
    logic          r_s2_col_ok;

    logic          r_out_v;
    logic          r_out_kind;
    logic [7:0]    r_out_shift;
    logic [6:0]    r_out_col;
    logic [2:0]    r_out_page;
    logic [7:0]    r_out_mask;
    logic          r_out_vis;

    logic          s2_adv;
    logic          pop;
    logic          do_load;
    logic          do_render;
    logic          pos0;
    logic          last;
    logic [7:0]    n_max;
    logic [7:0]    n_min;
    logic          spread_ok;
    logic          closer_hi;
    logic [7:0]    n_shift;
    logic [7:0]    rdata;
    logic [7:0]    y;
    logic          vis;

    assign s2_adv    = !r_out_v || o_out.ready;
    assign o_ready   = !r_s2_v || s2_adv;
    assign pop       = i_valid && o_ready;
    assign do_load   = pop && (i_cmd.op == OP_LOAD);
    assign do_render = pop && (i_cmd.op == OP_RENDER) && r_frame_ready;
    assign pos0      = r_load_count == '0;
    assign last      = r_load_count == LAST_POS;

    always_comb begin
        n_max = r_max;
        n_min = r_min;
        if (pos0) begin
            n_max = i_cmd.sample;
            n_min = i_cmd.sample;
        end else if (i_cmd.sample > r_max) begin
            n_max = i_cmd.sample;
        end else if (i_cmd.sample != 8'd0 && i_cmd.sample < r_min) begin
            n_min = i_cmd.sample;
        end
        spread_ok = 10'(n_max) >= 10'(n_min) + 10'(WINDOW_ROWS);
        closer_hi = {1'b0, i_cmd.sample, 1'b0} > 10'(n_max) + 10'(n_min);
        n_shift   = (spread_ok && closer_hi) ? n_max - TOP_OFFSET : n_min;
    end

    asp_ram #(.W(8), .D(COLUMNS)) u_store (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (r_load_count),
        .i_wdata (i_cmd.sample),
        .i_re    (do_render),
        .i_raddr (i_cmd.addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count  <= '0;
            r_max         <= '0;
            r_min         <= '0;
            r_scale_shift <= '0;
            r_frame_ready <= 1'b0;
        end else if (do_load) begin
            r_max <= n_max;
            r_min <= n_min;
            if (last) begin
                r_load_count  <= '0;
                r_frame_ready <= 1'b1;
                r_scale_shift <= n_shift;
            end else begin
                r_load_count <= r_load_count + 1'b1;
                if (pos0) begin
                    r_frame_ready <= 1'b0;
                end
            end
        end
    end

    // stage 2 waits on the registered store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (o_ready) begin
            r_s2_v <= (do_load && last) || do_render;
        end
        if (do_load && last) begin
            r_s2_kind   <= KIND_SHIFT;
            r_s2_shift  <= n_shift;
            r_s2_col    <= '0;
            r_s2_col_ok <= 1'b0;
        end else if (do_render) begin
            r_s2_kind   <= KIND_PIXEL;
            r_s2_shift  <= r_scale_shift;
            r_s2_col    <= i_cmd.column;
            r_s2_col_ok <= i_cmd.col_ok;
        end
    end

    assign y   = rdata - r_s2_shift;
    assign vis = (r_s2_kind == KIND_PIXEL) && r_s2_col_ok && (y < WINDOW_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s2_adv) begin
            r_out_v <= r_s2_v;
        end
        if (s2_adv && r_s2_v) begin
            r_out_kind  <= r_s2_kind;
            r_out_shift <= r_s2_shift;
            r_out_col   <= r_s2_col;
            r_out_vis   <= vis;
            r_out_page  <= vis ? BOTTOM_PAGE - y[5:3] : 3'd0;
            r_out_mask  <= vis ? TOP_MASK >> y[2:0] : 8'd0;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.kind       = r_out_kind;
    assign o_out.shift      = r_out_shift;
    assign o_out.column_out = r_out_col;
    assign o_out.page       = r_out_page;
    assign o_out.pixel_mask = r_out_mask;
    assign o_out.visible    = r_out_vis;

    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_count != '0) |-> (r_min <= r_max))
        else $error("running min above running max");

    a_report_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2_kind == KIND_SHIFT) |-> r_frame_ready)
        else $error("shift report without completed frame");

    a_vis_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_vis) |-> ($onehot(r_out_mask) && r_out_page >= 3'd3
                                    && r_out_kind == KIND_PIXEL))
        else $error("visible pixel with bad page or mask");

    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_vis) |-> (r_out_mask == 8'd0 && r_out_page == 3'd0))
        else $error("invisible result with nonzero page or mask");

    a_render_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_render |=> (r_s2_v && r_s2_kind == KIND_PIXEL))
        else $error("render word lost before stage 2");
endmodule
